// ----- src/assert_macros.svh -----
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SQF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqf assertion failed");

// next-cycle implication, disabled while reset is low
`define SQF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqf assertion failed");

`endif

// ----- src/sqf_pkg.sv -----
// types, constants and register indexes of the sogi quadrature filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sqf_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int FREQ_W       = 32;
  localparam int GAIN_W       = 24;
  localparam int PERIOD_W     = 32;
  localparam int STATE_W      = 48;
  localparam int XQ_W         = 48;
  localparam int OPND_W       = 64;
  localparam int ACC_W        = 2 * OPND_W;
  localparam int QUO_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RESONANT_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = CFG_IDX_W'(1);

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(128000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(109951163);

  localparam logic signed [OPND_W-1:0] ONE_Q40 = OPND_W'(64'h0000_0100_0000_0000);

  typedef enum logic [2:0] {
    OP_XQ, OP_C, OP_E, OP_CE, OP_T1, OP_T2, OP_CY, OP_BETA
  } sqf_op_t;

  typedef enum logic [2:0] {
    M_IDLE, M_PP0, M_PP1, M_PP2, M_PP3, M_RND, M_FIN
  } sqf_mphase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_POST, S_DIVW, S_OUT
  } sqf_state_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic [FREQ_W-1:0]              angular_freq;
  } sqf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] alpha_out;
    logic signed [SAMPLE_WIDTH-1:0] beta_out;
    logic                           zero_freq_flag;
  } sqf_out_t;

  typedef struct packed {
    logic              start;
    sqf_op_t           op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic              neg;
  } sqf_mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [OPND_W-1:0] res;
  } sqf_mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [XQ_W-1:0] den;
  } sqf_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } sqf_div_rsp_t;

endpackage

// ----- src/sqf_recip.sv -----
// restoring divider, one quotient bit per cycle: floor((2^64-1)/den)
// depends on sqf_pkg
`timescale 1ns / 1ps

module sqf_recip import sqf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sqf_div_req_t req,
  output sqf_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [XQ_W-1:0]  rem_r, rem_nxt;
  logic [XQ_W-1:0]  den_r, den_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [XQ_W:0]    trial;
  logic [XQ_W:0]    diff;
  logic             ge;

  // numerator bits are all ones
  assign trial = {rem_r, 1'b1};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(QUO_W);
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[XQ_W-1:0] : trial[XQ_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- src/sqf_scale_unit.sv -----
// shared scaled multiplier: |a|*|b| over four 32x32 partial products,
// rounded half away from zero (truncated for w*Ts), shifted and saturated per op; depends on sqf_pkg
`timescale 1ns / 1ps

module sqf_scale_unit import sqf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sqf_mul_req_t req,
  output sqf_mul_rsp_t rsp
);

  sqf_mphase_t              phase_r, phase_nxt;
  logic                     done_r, done_nxt;
  sqf_op_t                  op_r, op_nxt;
  logic [OPND_W-1:0]        a_r, a_nxt;
  logic [OPND_W-1:0]        b_r, b_nxt;
  logic                     neg_r, neg_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [OPND_W-1:0] res_r, res_nxt;

  logic [31:0]       pa, pb;
  logic [63:0]       pp;
  logic [ACC_W-1:0]  half;
  logic [ACC_W-1:0]  q;
  logic [OPND_W-1:0] top;
  logic [OPND_W-1:0] lim;
  logic [OPND_W-1:0] m;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  acc_sum;
  logic              over;

  // partial product select
  always_comb begin
    case (phase_r)
      M_PP1: begin
        pa = a_r[31:0];
        pb = b_r[63:32];
      end
      M_PP2: begin
        pa = a_r[63:32];
        pb = b_r[31:0];
      end
      M_PP3: begin
        pa = a_r[63:32];
        pb = b_r[63:32];
      end
      default: begin
        pa = a_r[31:0];
        pb = b_r[31:0];
      end
    endcase
  end

  assign pp = pa * pb;

  // rounding constant, output scaling and saturation bound per op
  always_comb begin
    case (op_r)
      OP_C: begin
        half = ACC_W'(1) << 40;
        q    = acc_r >> 41;
        top  = OPND_W'(1) << 62;
      end
      OP_E: begin
        half = ACC_W'(1) << 7;
        q    = acc_r >> 8;
        top  = OPND_W'(1) << (STATE_W - 1);
      end
      OP_CE, OP_T1, OP_CY: begin
        half = ACC_W'(1) << 39;
        q    = acc_r >> 40;
        top  = OPND_W'(1) << 61;
      end
      OP_T2: begin
        half = ACC_W'(1) << 38;
        q    = acc_r >> 39;
        top  = OPND_W'(1) << 61;
      end
      OP_BETA: begin
        half = ACC_W'(1) << 23;
        q    = acc_r >> 24;
        top  = OPND_W'(1) << (SAMPLE_WIDTH - 1);
      end
      default: begin
        // truncated w*Ts, no rounding
        half = '0;
        q    = acc_r >> 16;
        top  = '0;
      end
    endcase
  end

  assign lim  = (op_r == OP_XQ) ? '1 : (top - OPND_W'(!neg_r));
  assign over = (q[ACC_W-1:OPND_W] != '0) || (q[OPND_W-1:0] > lim);
  assign m    = over ? lim : q[OPND_W-1:0];

  always_comb begin
    case (phase_r)
      M_PP1, M_PP2: addend = {32'b0, pp, 32'b0};
      M_PP3:        addend = {pp, 64'b0};
      M_RND:        addend = half;
      default:      addend = {64'b0, pp};
    endcase
  end

  assign acc_sum = acc_r + addend;

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    case (phase_r)
      M_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          a_nxt     = req.a;
          b_nxt     = req.b;
          neg_nxt   = req.neg;
          acc_nxt   = '0;
          phase_nxt = M_PP0;
        end
      end
      M_PP0: begin
        acc_nxt   = acc_sum;
        phase_nxt = M_PP1;
      end
      M_PP1: begin
        acc_nxt   = acc_sum;
        phase_nxt = M_PP2;
      end
      M_PP2: begin
        acc_nxt   = acc_sum;
        phase_nxt = M_PP3;
      end
      M_PP3: begin
        acc_nxt   = acc_sum;
        phase_nxt = M_RND;
      end
      M_RND: begin
        acc_nxt   = acc_sum;
        phase_nxt = M_FIN;
      end
      M_FIN: begin
        res_nxt   = neg_r ? (OPND_W'(0) - m) : m;
        done_nxt  = 1'b1;
        phase_nxt = M_IDLE;
      end
      default: phase_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ----- src/sogi_quadrature_filter.sv -----
// Resonant SOGI quadrature filter, fixed point. One sample is worked on at a time, and the
// next sample is taken only once the result has gone to the output register. Each sample
// runs eight scaled products one after another through a single shared 32x32 multiplier
// (seven of them when w*Ts is zero), and the 64-step reciprocal divider for 1/(w*Ts), which
// starts after the first product, runs beside the multiplier and is awaited before the beta
// product. A new sample is taken while the previous result still waits in the output
// register; the next result then waits until that one is transferred out.
// Configuration writes are always accepted; write them only while the block is idle.
// Depends on sqf_pkg, sqf_scale_unit and sqf_recip.
`timescale 1ns / 1ps

module sogi_quadrature_filter import sqf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sqf_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sqf_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sqf_state_t state_r, state_nxt;
  sqf_op_t    op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  sqf_out_t   out_data_r, out_data_nxt;

  logic [GAIN_W-1:0]          gain_r, gain_nxt;
  logic [PERIOD_W-1:0]        period_r, period_nxt;
  logic signed [STATE_W-1:0]  po_r, po_nxt;
  logic signed [STATE_W-1:0]  ppo_r, ppo_nxt;
  logic signed [STATE_W-1:0]  pse_r, pse_nxt;

  logic signed [STATE_W-1:0]      u_r, u_nxt;
  logic [FREQ_W-1:0]              w_r, w_nxt;
  logic [XQ_W-1:0]                xq_r, xq_nxt;
  logic                           flag_r, flag_nxt;
  logic signed [OPND_W-1:0]       c_r, c_nxt;
  logic signed [STATE_W-1:0]      e_r, e_nxt;
  logic signed [62:0]             inner_r, inner_nxt;
  logic signed [61:0]             t1_r, t1_nxt;
  logic signed [STATE_W-1:0]      y_r, y_nxt;
  logic signed [62:0]             t_r, t_nxt;
  logic signed [SAMPLE_WIDTH-1:0] beta_r, beta_nxt;

  sqf_mul_req_t mul_req;
  sqf_mul_rsp_t mul_rsp;
  sqf_div_req_t div_req;
  sqf_div_rsp_t div_rsp;

  logic signed [STATE_W:0]        diff_e;
  logic signed [61:0]             res62;
  logic signed [OPND_W-1:0]       ysum;
  logic signed [SAMPLE_WIDTH-1:0] alpha;
  logic                           out_free;

  function automatic logic [OPND_W-1:0] mag64(input logic signed [OPND_W-1:0] v);
    return v[OPND_W-1] ? (OPND_W'(0) - v) : v;
  endfunction

  sqf_scale_unit u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  sqf_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign diff_e = (STATE_W + 1)'(u_r) - (STATE_W + 1)'(po_r);
  assign res62  = mul_rsp.res[61:0];
  assign ysum   = OPND_W'(t1_r) + mul_rsp.res - OPND_W'(ppo_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_req.start = (state_r == S_ISSUE);
    mul_req.op    = op_r;
    case (op_r)
      OP_C: begin
        mul_req.a   = OPND_W'(xq_r);
        mul_req.b   = OPND_W'(xq_r);
        mul_req.neg = 1'b0;
      end
      OP_E: begin
        mul_req.a   = OPND_W'(gain_r);
        mul_req.b   = mag64(OPND_W'(diff_e));
        mul_req.neg = diff_e[STATE_W];
      end
      OP_CE: begin
        mul_req.a   = mag64(c_r);
        mul_req.b   = mag64(OPND_W'(pse_r));
        mul_req.neg = c_r[OPND_W-1] ^ pse_r[STATE_W-1];
      end
      OP_T1: begin
        mul_req.a   = OPND_W'(period_r);
        mul_req.b   = mag64(OPND_W'(inner_r));
        mul_req.neg = inner_r[62];
      end
      OP_T2: begin
        mul_req.a   = mag64(c_r);
        mul_req.b   = mag64(OPND_W'(po_r));
        mul_req.neg = c_r[OPND_W-1] ^ po_r[STATE_W-1];
      end
      OP_CY: begin
        mul_req.a   = mag64(c_r);
        mul_req.b   = mag64(OPND_W'(y_r));
        mul_req.neg = c_r[OPND_W-1] ^ y_r[STATE_W-1];
      end
      OP_BETA: begin
        mul_req.a   = div_rsp.quo;
        mul_req.b   = mag64(OPND_W'(t_r));
        mul_req.neg = t_r[62];
      end
      default: begin
        mul_req.a   = OPND_W'(w_r);
        mul_req.b   = OPND_W'(period_r);
        mul_req.neg = 1'b0;
      end
    endcase
  end

  assign div_req.start = (state_r == S_POST) && (op_r == OP_XQ) &&
                         (mul_rsp.res[XQ_W-1:0] != '0);
  assign div_req.den   = mul_rsp.res[XQ_W-1:0];

  // alpha saturation to the sample width
  always_comb begin
    if (y_r[STATE_W-1:SAMPLE_WIDTH-1] == {(STATE_W - SAMPLE_WIDTH + 1){y_r[STATE_W-1]}}) begin
      alpha = y_r[SAMPLE_WIDTH-1:0];
    end else begin
      alpha = {y_r[STATE_W-1], {(SAMPLE_WIDTH - 1){~y_r[STATE_W-1]}}};
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    gain_nxt      = gain_r;
    period_nxt    = period_r;
    po_nxt        = po_r;
    ppo_nxt       = ppo_r;
    pse_nxt       = pse_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    xq_nxt        = xq_r;
    flag_nxt      = flag_r;
    c_nxt         = c_r;
    e_nxt         = e_r;
    inner_nxt     = inner_r;
    t1_nxt        = t1_r;
    y_nxt         = y_r;
    t_nxt         = t_r;
    beta_nxt      = beta_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESONANT_GAIN: gain_nxt   = cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: period_nxt = cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          u_nxt     = STATE_W'(in_data.sample_value);
          w_nxt     = in_data.angular_freq;
          op_nxt    = OP_XQ;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        state_nxt = S_ISSUE;
        case (op_r)
          OP_XQ: begin
            xq_nxt   = mul_rsp.res[XQ_W-1:0];
            flag_nxt = (mul_rsp.res[XQ_W-1:0] == '0);
            op_nxt   = OP_C;
          end
          OP_C: begin
            c_nxt  = ONE_Q40 - mul_rsp.res;
            op_nxt = OP_E;
          end
          OP_E: begin
            e_nxt  = mul_rsp.res[STATE_W-1:0];
            op_nxt = OP_CE;
          end
          OP_CE: begin
            inner_nxt = 63'(e_r) - 63'(res62);
            op_nxt    = OP_T1;
          end
          OP_T1: begin
            t1_nxt = res62;
            op_nxt = OP_T2;
          end
          OP_T2: begin
            if (ysum[OPND_W-1:STATE_W-1] == {(OPND_W - STATE_W + 1){ysum[OPND_W-1]}}) begin
              y_nxt = ysum[STATE_W-1:0];
            end else begin
              y_nxt = {ysum[OPND_W-1], {(STATE_W - 1){~ysum[OPND_W-1]}}};
            end
            op_nxt = OP_CY;
          end
          OP_CY: begin
            t_nxt = 63'(po_r) - 63'(res62);
            if (flag_r) begin
              beta_nxt  = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_DIVW;
            end
          end
          OP_BETA: begin
            beta_nxt  = mul_rsp.res[SAMPLE_WIDTH-1:0];
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          op_nxt    = OP_BETA;
          state_nxt = S_ISSUE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.alpha_out      = alpha;
          out_data_nxt.beta_out       = beta_r;
          out_data_nxt.zero_freq_flag = flag_r;
          ppo_nxt                     = po_r;
          po_nxt                      = y_r;
          pse_nxt                     = e_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_XQ;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
      period_r    <= PERIOD_RESET;
      po_r        <= '0;
      ppo_r       <= '0;
      pse_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
      period_r    <= period_nxt;
      po_r        <= po_nxt;
      ppo_r       <= ppo_nxt;
      pse_r       <= pse_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    u_r        <= u_nxt;
    w_r        <= w_nxt;
    xq_r       <= xq_nxt;
    flag_r     <= flag_nxt;
    c_r        <= c_nxt;
    e_r        <= e_nxt;
    inner_r    <= inner_nxt;
    t1_r       <= t1_nxt;
    y_r        <= y_nxt;
    t_r        <= t_nxt;
    beta_r     <= beta_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- src/sqf_checker.sv -----
// port-level checks of the sogi quadrature filter and their bind
// depends on sqf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sqf_checker import sqf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sqf_out_t out_data
);

  // a stalled result holds
  `SQF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // one sample at a time: busy right after a transfer in
  `SQF_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)

  // no result can show up the cycle after a transfer in
  `SQF_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

  // zero w*Ts forces the quadrature output to zero
  `SQF_ASSERT_IMPL(a_flag_beta, clk, rst_n, out_valid && out_data.zero_freq_flag, out_data.beta_out == '0)

endmodule

bind sogi_quadrature_filter sqf_checker u_sqf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sogi_quadrature_filter_tb.sv -----
// self-checking testbench for sogi_quadrature_filter: directed and random grid samples,
// predicted in fixed point by a scoreboard class and compared field by field
// depends on sqf_pkg and the sogi_quadrature_filter rtl
`timescale 1ns / 1ps

module sogi_quadrature_filter_tb import sqf_pkg::*;;

  localparam int LIMIT_CYCLES   = 600000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_CHUNKS     = 6;
  localparam int ITEMS_PER_CHUNK = 92;

  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LIST = REG_SAMPLE_PERIOD + 1'b1;

  localparam logic signed [SAMPLE_WIDTH-1:0] U_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_WIDTH-1:0] U_MIN = 32'sh8000_0000;
  localparam logic [FREQ_W-1:0] W_GRID = 32'd20588483;
  localparam logic [FREQ_W-1:0] W_MAX  = 32'hFFFF_FFFF;

  class quadrature_checker;
    logic [GAIN_W-1:0]   gain_q16_8;
    logic [PERIOD_W-1:0] period_q0_40;
    longint              y_prev;
    longint              y_prev2;
    longint              err_prev;
    sqf_out_t            pending_results[$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    function new();
      gain_q16_8   = GAIN_RESET;
      period_q0_40 = PERIOD_RESET;
      y_prev       = 0;
      y_prev2      = 0;
      err_prev     = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("ERROR: %s", msg);
      mismatches++;
    endtask

    // |a|*|b| rounded half away from zero by 2^s, saturated to n signed bits
    function longint round_product(bit [63:0] a, bit [63:0] b, bit neg, int s, int n);
      bit [127:0] p;
      bit [127:0] q;
      bit [63:0]  lim;
      bit [63:0]  m;
      p = a * b;
      p = p + (128'd1 << (s - 1));
      q = p >> s;
      lim = (64'd1 << (n - 1)) - (neg ? 64'd0 : 64'd1);
      if (q[127:64] != 0) m = lim;
      else m = q[63:0];
      if (m > lim) m = lim;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function bit [63:0] magnitude(longint v);
      return (v < 0) ? (64'd0 - v) : v;
    endfunction

    function longint signed_product(longint a, longint b, int s, int n);
      return round_product(magnitude(a), magnitude(b), (a < 0) != (b < 0), s, n);
    endfunction

    function longint clamp(longint v, int n);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (n - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RESONANT_GAIN: gain_q16_8 = data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: period_q0_40 = data[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(sqf_in_t d);
      longint     u;
      longint     c;
      longint     e;
      longint     inner;
      longint     t1;
      longint     t2;
      longint     y;
      longint     diff;
      longint     beta;
      bit [63:0]  xq;
      bit [63:0]  inv;
      bit         zero_x;
      sqf_out_t   r;
      u = longint'(d.sample_value);
      xq = (64'(d.angular_freq) * 64'(period_q0_40)) >> 16;
      zero_x = (xq == 0);
      c = ONE_Q40 - round_product(xq, xq, 1'b0, 41, 63);
      e = signed_product(longint'(gain_q16_8), u - y_prev, 8, 48);
      inner = e - signed_product(c, err_prev, 40, 62);
      t1 = signed_product(longint'(period_q0_40), inner, 40, 62);
      t2 = signed_product(c, y_prev, 39, 62);
      y = clamp(t1 + t2 - y_prev2, 48);
      beta = 0;
      if (!zero_x) begin
        inv = 64'hFFFF_FFFF_FFFF_FFFF / xq;
        diff = y_prev - signed_product(c, y, 40, 62);
        beta = round_product(inv, magnitude(diff), diff < 0, 24, SAMPLE_WIDTH);
      end
      y_prev2 = y_prev;
      y_prev = y;
      err_prev = e;
      r.alpha_out = SAMPLE_WIDTH'(clamp(y, SAMPLE_WIDTH));
      r.beta_out = SAMPLE_WIDTH'(beta);
      r.zero_freq_flag = zero_x;
      pending_results.push_back(r);
    endfunction

    task check_result(sqf_out_t got);
      sqf_out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d with none pending: alpha %0d beta %0d flag %0b",
                         results_seen, got.alpha_out, got.beta_out, got.zero_freq_flag));
        return;
      end
      want = pending_results.pop_front();
      if (got.alpha_out !== want.alpha_out)
        report($sformatf("result %0d alpha_out got %0d expected %0d",
                         results_seen, got.alpha_out, want.alpha_out));
      if (got.beta_out !== want.beta_out)
        report($sformatf("result %0d beta_out got %0d expected %0d",
                         results_seen, got.beta_out, want.beta_out));
      if (got.zero_freq_flag !== want.zero_freq_flag)
        report($sformatf("result %0d zero_freq_flag got %0b expected %0b",
                         results_seen, got.zero_freq_flag, want.zero_freq_flag));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sqf_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  sqf_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  quadrature_checker chk = new();

  int          send_idle_pct = 34;
  int          recv_idle_pct = 60;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;
  real         grid_amp = 325.0 * 65536.0;
  real         grid_phase = 0.0;

  sogi_quadrature_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // transfers seen at each edge, in the order config, input, result
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) chk.set_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) chk.note_sample(in_data);
      if (out_valid && !out_stall) chk.check_result(out_data);
    end
  end

  // result side stalls, with an occasional long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_requested) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic sqf_in_t sample_of(logic [SAMPLE_WIDTH-1:0] u, logic [FREQ_W-1:0] w);
    sqf_in_t d;
    d.sample_value = u;
    d.angular_freq = w;
    return d;
  endfunction

  function automatic sqf_in_t random_sample();
    sqf_in_t     d;
    int unsigned pick;
    pick = $urandom_range(99);
    d.sample_value = $urandom();
    d.angular_freq = $urandom();
    if (pick < 60) begin
      d.sample_value = $rtoi(grid_amp * $sin(grid_phase));
      d.angular_freq = W_GRID + $urandom_range(2000000) - 1000000;
      grid_phase = grid_phase + 0.0314;
    end else if (pick < 72) begin
      d.angular_freq = $urandom_range(70000);
    end else if (pick < 80) begin
      d.sample_value = $urandom_range(1) ? U_MAX : U_MIN;
    end else if (pick < 86) begin
      d.angular_freq = $urandom_range(1) ? W_MAX : '0;
    end
    return d;
  endfunction

  task automatic send_sample(input sqf_in_t d);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(7) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] gain,
                           input logic [CFG_DATA_W-1:0] period);
    cfg_valid <= 1'b1;
    cfg_index <= REG_RESONANT_GAIN;
    cfg_data <= gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_SAMPLE_PERIOD;
    cfg_data <= period;
    do @(posedge clk); while (!cfg_ready);
    // writes past the register list must be ignored
    cfg_index <= REG_BEYOND_LIST + CFG_IDX_W'($urandom_range(1));
    cfg_data <= $urandom();
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] period;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RESONANT_GAIN;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the registers, junk in the unused upper gain bits
    configure({8'hA5, GAIN_RESET}, PERIOD_RESET);
    send_sample(sample_of('0, '0));
    send_sample(sample_of(U_MAX, W_GRID));
    send_sample(sample_of(U_MIN, W_GRID));
    send_sample(sample_of(U_MAX, W_MAX));
    send_sample(sample_of(U_MIN, W_MAX));
    send_sample(sample_of('0, 32'd1));
    send_sample(sample_of('1, 32'd65536));
    send_sample(sample_of(32'sd1, '0));

    // largest gain and period
    wait_for_drain();
    configure('1, '1);
    send_sample(sample_of(U_MAX, '0));
    send_sample(sample_of(U_MAX, 32'd1));
    send_sample(sample_of(U_MIN, W_MAX));
    send_sample(sample_of(U_MIN, W_GRID));
    send_sample(sample_of(U_MAX, W_MAX));

    // zero gain, smallest period: nonzero w can still give a zero product
    wait_for_drain();
    configure('0, 32'd1);
    send_sample(sample_of(U_MAX, 32'd65535));
    send_sample(sample_of(U_MIN, 32'd65536));
    send_sample(sample_of('0, W_MAX));
    send_sample(sample_of(U_MAX, '0));

    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      wait_for_drain();
      if (chunk < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 60;
      end else if (chunk < 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (chunk)
        0: begin gain = GAIN_RESET; period = PERIOD_RESET; end
        1: begin gain = '1; period = '1; end
        2: begin gain = '0; period = 32'd1; end
        3: begin gain = $urandom(); period = $urandom_range(32'hFFFF_FFFF, 1); end
        4: begin gain = 32'd256; period = 32'd21990233; end
        default: begin gain = 32'd25600; period = 32'd1099511628; end
      endcase
      configure(gain, period);
      grid_amp = real'($urandom_range(400)) * 65536.0;
      if (chunk == 1 || chunk == 4) holds_requested++;
      repeat (ITEMS_PER_CHUNK) send_sample(random_sample());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.pending_results.size() != 0)
      chk.report($sformatf("%0d results never arrived", chk.pending_results.size()));
    if (chk.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
